### sv/paid_pkg.sv
// Shared types and codes for the positional array insert/delete/search block.
// Used by paid_mem, paid_core and positional_array_insert_delete_search_top.
package paid_pkg;

   localparam int CapacityDefault = 128;

   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_SEARCH = 3'd2,
      CMD_CLEAR  = 3'd3,
      CMD_READ   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_EMPTY    = 3'd2,
      STAT_BADPOS   = 3'd3,
      STAT_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_PUT,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_RD_RD,
      ST_RD_DATA,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [7:0]         position;
      logic signed [31:0] value;
   } request_type;

   typedef struct packed {
      status_type         status;
      logic [7:0]         found_position;
      logic signed [31:0] read_data;
      logic [7:0]         entry_count;
   } result_type;

endpackage

### sv/paid_mem.sv
// Entry store: one write port, one read port with registered read data.
// Depends on paid_pkg for the default depth.
module paid_mem
   import paid_pkg::*;
#(
   parameter int Depth = CapacityDefault,
   localparam int AddrW = $clog2(Depth)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AddrW-1:0]        wr_addr,
   input  logic signed [31:0]      wr_data,
   input  logic [AddrW-1:0]        rd_addr,
   output logic signed [31:0]      rd_data
);

   logic signed [31:0] mem_ff [Depth];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/paid_core.sv
// Command sequencer: walks the entry store one entry per step for shifts and search.
// Depends on paid_pkg and paid_mem.
module paid_core
   import paid_pkg::*;
#(
   parameter int Capacity = CapacityDefault,
   localparam int AddrW = $clog2(Capacity)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  request_type req,
   output logic        idle,
   output logic        done_valid,
   input  logic        done_ready,
   output result_type  result
);

   localparam logic [7:0] CapLimit = 8'(Capacity);

   state_type          state_ff, state_in;
   logic [7:0]         count_ff, count_in;
   logic [7:0]         idx_ff, idx_in;
   logic [7:0]         pos_ff, pos_in;
   logic signed [31:0] val_ff, val_in;
   status_type         status_ff, status_in;
   logic [7:0]         found_ff, found_in;
   logic signed [31:0] rdata_ff, rdata_in;

   logic               wr_en;
   logic [AddrW-1:0]   wr_addr;
   logic signed [31:0] wr_data;
   logic [AddrW-1:0]   rd_addr;
   logic signed [31:0] rd_data;

   logic [7:0]         idx_dn, idx_up, pos_m1, req_pos_m1;
   logic [8:0]         count_p1, idx_p2;

   assign idx_dn     = idx_ff - 8'd1;
   assign idx_up     = idx_ff + 8'd1;
   assign pos_m1     = pos_ff - 8'd1;
   assign req_pos_m1 = req.position - 8'd1;
   assign count_p1   = {1'b0, count_ff} + 9'd1;
   assign idx_p2     = {1'b0, idx_ff} + 9'd2;

   paid_mem #(.Depth(Capacity)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= 8'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rdata_ff  <= rdata_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      status_in = status_ff;
      found_in  = found_ff;
      rdata_in  = rdata_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AddrW-1:0];
      wr_data   = rd_data;
      rd_addr   = idx_ff[AddrW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pos_in    = req.position;
               val_in    = req.value;
               status_in = STAT_OK;
               found_in  = 8'd0;
               rdata_in  = 32'sd0;
               state_in  = ST_DONE;
               unique case (req.cmd)
                  CMD_INSERT: begin
                     if (count_ff >= CapLimit) begin
                        status_in = STAT_FULL;
                     end else if (req.position == 8'd0 || {1'b0, req.position} > count_p1) begin
                        status_in = STAT_BADPOS;
                     end else if ({1'b0, req.position} == count_p1) begin
                        // append: no shift needed
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AddrW-1:0];
                        wr_data  = req.value;
                        count_in = count_ff + 8'd1;
                     end else begin
                        idx_in   = count_ff;
                        state_in = ST_INS_RD;
                     end
                  end
                  CMD_DELETE: begin
                     if (count_ff == 8'd0) begin
                        status_in = STAT_EMPTY;
                     end else if (req.position == 8'd0 || req.position > count_ff) begin
                        status_in = STAT_BADPOS;
                     end else if (req.position == count_ff) begin
                        count_in = count_ff - 8'd1;
                     end else begin
                        idx_in   = req_pos_m1;
                        state_in = ST_DEL_RD;
                     end
                  end
                  CMD_SEARCH: begin
                     status_in = STAT_NOTFOUND;
                     if (count_ff != 8'd0) begin
                        idx_in   = 8'd0;
                        state_in = ST_SRCH_RD;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = 8'd0;
                  end
                  CMD_READ: begin
                     if (count_ff == 8'd0) begin
                        status_in = STAT_EMPTY;
                     end else if (req.position == 8'd0 || req.position > count_ff) begin
                        status_in = STAT_BADPOS;
                     end else begin
                        idx_in   = req_pos_m1;
                        state_in = ST_RD_RD;
                     end
                  end
                  default: begin
                     status_in = STAT_BADPOS;
                  end
               endcase
            end
         end
         ST_INS_RD: begin
            rd_addr  = idx_dn[AddrW-1:0];
            state_in = ST_INS_WR;
         end
         ST_INS_WR: begin
            // move the entry below up by one
            wr_en = 1'b1;
            if (idx_ff == pos_ff) begin
               state_in = ST_INS_PUT;
            end else begin
               idx_in   = idx_dn;
               state_in = ST_INS_RD;
            end
         end
         ST_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_m1[AddrW-1:0];
            wr_data  = val_ff;
            count_in = count_ff + 8'd1;
            state_in = ST_DONE;
         end
         ST_DEL_RD: begin
            rd_addr  = idx_up[AddrW-1:0];
            state_in = ST_DEL_WR;
         end
         ST_DEL_WR: begin
            wr_en = 1'b1;
            if (idx_p2 >= {1'b0, count_ff}) begin
               count_in = count_ff - 8'd1;
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_up;
               state_in = ST_DEL_RD;
            end
         end
         ST_SRCH_RD: begin
            state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            if (rd_data == val_ff) begin
               status_in = STAT_OK;
               found_in  = idx_up;
               state_in  = ST_DONE;
            end else if (idx_up == count_ff) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_up;
               state_in = ST_SRCH_RD;
            end
         end
         ST_RD_RD: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            rdata_in = rd_data;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign idle       = (state_ff == ST_IDLE);
   assign done_valid = (state_ff == ST_DONE);

   assign result.status         = status_ff;
   assign result.found_position = found_ff;
   assign result.read_data      = rdata_ff;
   assign result.entry_count    = count_ff;

endmodule

### sv/positional_array_insert_delete_search_top.sv
// Positional array with insert, delete, linear search, clear and read.
// One command is in work at a time; clear, append, drop of the last entry and refused
// commands finish without a memory pass, read takes one memory read, and insert,
// delete and search step through the entries one at a time: one memory read port
// serves every shift step and compare.
// A waiting result does not block the next request. Synchronous reset empties the list.
module positional_array_insert_delete_search_top
   import paid_pkg::*;
#(
   parameter int Capacity = CapacityDefault
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] position, [39:8] value
   input  logic [2:0]  req_tuser,   // [2:0] cmd
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] found_position, [39:8] read_data,
                                    // [47:40] entry_count
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   request_type req;
   result_type  core_result;
   logic        core_idle;
   logic        core_done;
   logic        load;

   // Response holding register: frees the sequencer as soon as a result lands.
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_res_ff, rsp_res_in;

   assign req.cmd      = req_tuser;
   assign req.position = req_tdata[7:0];
   assign req.value    = req_tdata[39:8];

   // Take a request only while the sequencer has nothing in flight.
   assign req_tready = core_idle;

   paid_core #(.Capacity(Capacity)) u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (req_tvalid & core_idle),
      .req        (req),
      .idle       (core_idle),
      .done_valid (core_done),
      .done_ready (load),
      .result     (core_result)
   );

   // Load a finished result when the holding register is empty or draining.
   assign load = core_done & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_res_in   = rsp_res_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tdata  = {rsp_res_ff.entry_count, rsp_res_ff.read_data,
                        rsp_res_ff.found_position};

endmodule
